>>> rtl/vpr_pkg.sv
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared widths, codes and parameter defaults for the vertex property reduce
// block.
// ----------------------------------------------------------------------------
package vpr_pkg;

  // Fixed field widths of the channels
  localparam int VERTEX_W = 16;
  localparam int DATA_W   = 32;

  // Defaults for the top level parameters
  localparam int VERTEX_COUNT_DEF = 65536;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Item action codes
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_UPDATE = 1'b1;

  // Reduce mode codes
  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MIN = 1'b1;

endpackage

>>> rtl/vpr_channels.sv
// ----------------------------------------------------------------------------
// vpr_channels
// Valid/ready channel interfaces for update items and result items.
// ----------------------------------------------------------------------------
interface vpr_in_if;
  import vpr_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [VERTEX_W-1:0] vertex;
  logic [DATA_W-1:0]   value;

  modport source (output valid, output action, output vertex, output value, input ready);
  modport sink   (input valid, input action, input vertex, input value, output ready);
endinterface

interface vpr_out_if;
  import vpr_pkg::*;

  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex_out;
  logic [DATA_W-1:0]   new_value;
  logic                changed;

  modport source (output valid, output vertex_out, output new_value, output changed,
                  input ready);
  modport sink   (input valid, input vertex_out, input new_value, input changed,
                  output ready);
endinterface

>>> rtl/vertex_property_reduce.sv
// ----------------------------------------------------------------------------
// vertex_property_reduce
// Gather stage of a graph engine: keeps one property value per vertex and
// folds load and update transactions into it.
// ----------------------------------------------------------------------------
// Each input transaction passes through the sequencer states in order: the
// accept state, one for the reciprocal multiply that wraps the vertex number
// into the table (spent even when the table size is a power of two), one for
// the table read (the RAM has a registered read), and one to combine, write
// back and load the output register. The result enters the output register
// at the end of the combine step, and the block is ready for the next
// transaction in the following cycle. A result may wait in the output
// register while the next transaction is accepted; if it is still there when
// that transaction reaches the combine step, the step waits.
// A load stores the value and reports changed as 0; an update adds the
// message (mode 0, wrapping) or keeps the unsigned minimum (mode 1) and
// reports whether the stored value moved. The table is not cleared after
// reset, so every vertex must be loaded before it is updated. Write the
// reduce mode only while the block is idle.
// ----------------------------------------------------------------------------
module vertex_property_reduce #(
  parameter int VERTEX_COUNT = vpr_pkg::VERTEX_COUNT_DEF,
  parameter int VALUE_WIDTH  = vpr_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  vpr_in_if.sink           in_ch,
  vpr_out_if.source        out_ch
);
  import vpr_pkg::*;

  localparam int ADDR_W = $clog2(VERTEX_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUOT,
    S_ADDR,
    S_COMB
  } state_t;

  state_t                 state;
  logic                   reduce_mode;
  logic                   action_r;
  logic [VERTEX_W-1:0]    vertex_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [ADDR_W-1:0]      index;
  logic [ADDR_W-1:0]      addr;
  logic [VALUE_WIDTH-1:0] old_value;
  logic [VALUE_WIDTH-1:0] sum;
  logic [VALUE_WIDTH-1:0] result;
  logic                   changed;
  logic                   out_free;
  logic                   wr_en;
  logic                   out_valid;
  logic [VERTEX_W-1:0]    out_vertex;
  logic [DATA_W-1:0]      out_value;
  logic                   out_changed;

  // Vertex wrap unit
  vpr_index #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_index (
    .clk    (clk),
    .vertex (vertex_r),
    .index  (index)
  );

  // Property table
  vpr_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(VERTEX_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (result),
    .re    (state == S_ADDR),
    .raddr (index),
    .rdata (old_value)
  );

  // Combine the message with the stored value
  assign sum = old_value + value_r;

  always_comb begin
    if (action_r == ACTION_LOAD) begin
      result = value_r;
    end else if (reduce_mode == MODE_SUM) begin
      result = sum;
    end else begin
      result = (value_r < old_value) ? value_r : old_value;
    end
  end

  assign changed  = (action_r == ACTION_UPDATE) && (result != old_value);
  assign out_free = !out_valid || out_ch.ready;
  assign wr_en    = (state == S_COMB) && out_free;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_MIN;
    end else if (cfg_we) begin
      reduce_mode <= cfg_wdata;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !wr_en) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            action_r <= in_ch.action;
            vertex_r <= in_ch.vertex;
            value_r  <= VALUE_WIDTH'(in_ch.value);
            state    <= S_QUOT;
          end
        end
        S_QUOT: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr  <= index;
          state <= S_COMB;
        end
        S_COMB: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_vertex  <= VERTEX_W'(addr);
            out_value   <= DATA_W'(result);
            out_changed <= changed;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.vertex_out = out_vertex;
  assign out_ch.new_value  = out_value;
  assign out_ch.changed    = out_changed;

endmodule

>>> rtl/vpr_ram.sv
// ----------------------------------------------------------------------------
// vpr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module vpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/vpr_index.sv
// ----------------------------------------------------------------------------
// vpr_index
// Wraps a vertex number into the table range. For a table that is not a
// power of two, the quotient is estimated by a reciprocal multiply and
// registered, and the remainder is then corrected from the registered quotient.
// ----------------------------------------------------------------------------
module vpr_index #(
  parameter int VERTEX_COUNT = vpr_pkg::VERTEX_COUNT_DEF
) (
  input  logic                            clk,
  input  logic [vpr_pkg::VERTEX_W-1:0]    vertex,
  output logic [$clog2(VERTEX_COUNT)-1:0] index
);
  import vpr_pkg::*;

  localparam int ADDR_W = $clog2(VERTEX_COUNT);

  generate
    if (VERTEX_COUNT >= (1 << VERTEX_W)) begin : g_wide
      // Every vertex number fits the table
      assign index = ADDR_W'(vertex);
    end else if ((VERTEX_COUNT & (VERTEX_COUNT - 1)) == 0) begin : g_pow2
      // Drop the high bits
      assign index = vertex[ADDR_W-1:0];
    end else begin : g_recip
      localparam longint unsigned RECIP = (64'd1 << 32) / VERTEX_COUNT;
      localparam int              REM_W = VERTEX_W + 1;

      logic [VERTEX_W+31:0] prod;
      logic [VERTEX_W-1:0]  quot;
      logic [31:0]          back;
      logic [REM_W-1:0]     rem;
      logic [REM_W-1:0]     rem_fix;

      // Quotient estimate, low by at most one
      assign prod = (VERTEX_W+32)'(vertex) * (VERTEX_W+32)'(RECIP);

      always_ff @(posedge clk) begin
        quot <= prod[VERTEX_W+31:32];
      end

      // Remainder with one correction step
      assign back    = 32'(quot) * 32'(VERTEX_COUNT);
      assign rem     = REM_W'(vertex) - REM_W'(back);
      assign rem_fix = (rem >= REM_W'(VERTEX_COUNT)) ? rem - REM_W'(VERTEX_COUNT) : rem;
      assign index   = ADDR_W'(rem_fix);
    end
  endgenerate

endmodule

>>> rtl/vpr_checker.sv
// ----------------------------------------------------------------------------
// vpr_checker
// Port-level checks for vertex_property_reduce: transaction accounting and
// output hold.
// ----------------------------------------------------------------------------
module vpr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vpr_pkg::VERTEX_W-1:0] out_vertex,
  input logic [vpr_pkg::DATA_W-1:0]   out_value,
  input logic                         out_changed
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // No result without a transaction behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 2'd0))
    else $error("result delivered with no transaction pending");

  // At most one transaction in work and one waiting at the output
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (pending != 2'd2))
    else $error("transaction accepted with the block full");

  // One transaction at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input ready right after an accept");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_vertex) && $stable(out_value) && $stable(out_changed)))
    else $error("stalled result changed");

endmodule

bind vertex_property_reduce vpr_checker u_vpr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_vertex  (out_ch.vertex_out),
  .out_value   (out_ch.new_value),
  .out_changed (out_ch.changed)
);

>>> bench/vertex_property_reduce_tb.sv
// ----------------------------------------------------------------------------
// vertex_property_reduce_tb
// Self-checking bench for the vertex property gather stage. A scoreboard
// predicts the stored value, the reported vertex and the changed flag of every
// accepted transaction and compares each result in order. Stimulus is a short
// directed list, then random phases that alternate sum and minimum modes and
// concentrate on a few hot vertices so that updates to the same vertex follow
// each other closely. Both channels idle at random.
// ----------------------------------------------------------------------------
module vertex_property_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vpr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 100;
  localparam int PHASE_COUNT  = 5;
  localparam int HOT_COUNT    = 8;
  localparam int MAX_PRINTS   = 40;

  // Predicts the property table and checks results in arrival order
  class reduce_scoreboard;
    typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [DATA_W-1:0]   value;
      logic                changed;
    } result_t;

    logic [DATA_W-1:0] prop_mem [VERTEX_COUNT_DEF];
    logic              mode;
    result_t           expected_q [$];
    int                errors;
    int                checked;
    int                n_loads;
    int                n_updates;
    int                n_changed;
    int                n_sum;
    int                n_min;

    function new();
      mode      = MODE_MIN;
      errors    = 0;
      checked   = 0;
      n_loads   = 0;
      n_updates = 0;
      n_changed = 0;
      n_sum     = 0;
      n_min     = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Fold one accepted transaction into the table and queue its result
    function void note_input(logic act, logic [VERTEX_W-1:0] vtx, logic [DATA_W-1:0] val);
      result_t           r;
      logic [DATA_W-1:0] prior;
      r.vertex  = vtx;
      r.changed = 1'b0;
      if (act == ACTION_LOAD) begin
        r.value = val;
        n_loads++;
      end else begin
        prior = prop_mem[vtx];
        if (mode == MODE_SUM) begin
          r.value = prior + val;
          n_sum++;
        end else begin
          r.value = (val < prior) ? val : prior;
          n_min++;
        end
        r.changed = (r.value != prior);
        n_updates++;
        if (r.changed) n_changed++;
      end
      prop_mem[vtx] = r.value;
      expected_q = {expected_q, r};
    endfunction

    // Compare one result against the oldest expectation
    task check_result(logic [VERTEX_W-1:0] vtx, logic [DATA_W-1:0] val, logic chg);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: vertex %h value %h", vtx, val));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (vtx !== want.vertex)
          report_mismatch($sformatf("vertex_out %h, want %h", vtx, want.vertex));
        if (val !== want.value)
          report_mismatch($sformatf("new_value %h, want %h (vertex %h)", val, want.value,
                                    want.vertex));
        if (chg !== want.changed)
          report_mismatch($sformatf("changed %b, want %b (vertex %h)", chg, want.changed,
                                    want.vertex));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  vpr_in_if  in_ch ();
  vpr_out_if out_ch ();

  vertex_property_reduce #(
    .VERTEX_COUNT(VERTEX_COUNT_DEF),
    .VALUE_WIDTH (VALUE_WIDTH_DEF)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  reduce_scoreboard sb = new();

  bit                  loaded_map [VERTEX_COUNT_DEF];
  logic [VERTEX_W-1:0] hot_set [HOT_COUNT];
  int                  burst_left = 0;
  int                  cycle_count = 0;
  int                  mode_writes = 0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("vertex_property_reduce regression: fail");
      $finish;
    end
  end

  // Sample both channels at the rising edge: note inputs, check results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.action, in_ch.vertex, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.vertex_out, out_ch.new_value, out_ch.changed);
    end
  end

  // Receiver stall pattern: segments of always-ready, sparse stalls, long holds
  int   stall_style = 0;
  int   seg_left    = 0;
  int   hold_left   = 0;
  logic hold_level  = 1'b1;

  always @(negedge clk) begin
    if (seg_left == 0) begin
      stall_style = $urandom_range(0, 2);
      seg_left    = $urandom_range(16, 96);
    end
    seg_left--;
    case (stall_style)
      0: begin
        out_ch.ready = 1'b1;
      end
      1: begin
        out_ch.ready = ($urandom_range(0, 2) != 0);
      end
      default: begin
        if (hold_left == 0) begin
          hold_left  = $urandom_range(1, 12);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_ch.ready = hold_level;
      end
    endcase
  end

  // Present one transaction and hold it until accepted; gaps fall between bursts
  task automatic send_item(logic act, logic [VERTEX_W-1:0] vtx, logic [DATA_W-1:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.vertex = vtx;
    in_ch.value  = val;
    if (act == ACTION_LOAD) loaded_map[vtx] = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write the reduce mode once the block has gone idle
  task automatic write_mode(logic m);
    drain();
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    sb.set_mode(m);
    mode_writes++;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = ~m;
  endtask

  // Message values biased toward extremes and toward the stored value
  function automatic logic [DATA_W-1:0] pick_value(logic [VERTEX_W-1:0] vtx);
    logic [DATA_W-1:0] stored;
    stored = sb.prop_mem[vtx];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DATA_W'($urandom_range(0, 15));
      3: return stored - DATA_W'($urandom_range(0, 3));
      4: return stored + DATA_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // One random phase: mostly hot vertices, loads before any update
  task automatic run_phase(int phase, int count);
    logic [VERTEX_W-1:0] vtx;
    logic                act;
    for (int i = 0; i < HOT_COUNT; i++) hot_set[i] = VERTEX_W'($urandom);
    if (phase == 0) begin
      hot_set[0] = '0;
      hot_set[1] = '1;
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 70) vtx = hot_set[$urandom_range(0, HOT_COUNT - 1)];
      else vtx = VERTEX_W'($urandom);
      if (!loaded_map[vtx]) act = ACTION_LOAD;
      else act = ($urandom_range(0, 99) < 25) ? ACTION_LOAD : ACTION_UPDATE;
      send_item(act, vtx, (act == ACTION_LOAD) ? DATA_W'($urandom) : pick_value(vtx));
      // Hold the sender off mid-phase once so the pipeline empties completely
      if (phase == 2 && n == count / 2) drain();
    end
  endtask

  // Main sequence
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACTION_LOAD;
    in_ch.vertex = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: minimum mode straight out of reset, back to back
    burst_left = 1000;
    send_item(ACTION_LOAD,   16'h0000, 32'h0000_0000);
    send_item(ACTION_LOAD,   16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'hFFFF, 32'hFFFF_FFFE);
    send_item(ACTION_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'h0000, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'h0000, 32'h0000_0000);
    send_item(ACTION_LOAD,   16'h8000, 32'd100);
    send_item(ACTION_UPDATE, 16'h8000, 32'd50);
    send_item(ACTION_UPDATE, 16'h8000, 32'd10);
    send_item(ACTION_UPDATE, 16'h8000, 32'd60);
    send_item(ACTION_LOAD,   16'h8000, 32'd7);
    send_item(ACTION_UPDATE, 16'h8000, 32'd3);

    // Directed: sum mode with wraparound and repeated hits on one vertex
    burst_left = 0;
    write_mode(MODE_SUM);
    burst_left = 1000;
    send_item(ACTION_LOAD,   16'h1234, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'h1234, 32'h0000_0001);
    send_item(ACTION_UPDATE, 16'h1234, 32'h0000_0000);
    send_item(ACTION_UPDATE, 16'h1234, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'h1234, 32'hFFFF_FFFF);
    send_item(ACTION_UPDATE, 16'hFFFF, 32'h0000_0001);
    send_item(ACTION_UPDATE, 16'h0000, 32'h5555_5555);
    send_item(ACTION_UPDATE, 16'h0000, 32'hAAAA_AAAA);
    send_item(ACTION_LOAD,   16'h5555, 32'h0000_0000);
    send_item(ACTION_UPDATE, 16'h5555, 32'h0000_0001);
    burst_left = 0;

    // Random phases alternating minimum and sum
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_mode((p % 2 == 0) ? MODE_MIN : MODE_SUM);
      run_phase(p, PHASE_ITEMS);
    end

    // Wait out the tail of the pipeline
    drain();
    repeat (16) @(negedge clk);

    $display("covered %0d loads, %0d updates (%0d sum, %0d min), %0d changed vertices",
             sb.n_loads, sb.n_updates, sb.n_sum, sb.n_min, sb.n_changed);
    $display("checked %0d results over %0d mode writes, %0d mismatches",
             sb.checked, mode_writes, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("vertex_property_reduce regression: pass");
    end else begin
      $display("vertex_property_reduce regression: fail");
    end
    $finish;
  end

endmodule
